// File: hw/rtl/msp_pkg.sv
// Package with the item types, opcodes and constants of the minimal standard generator.
package msp_pkg;

  localparam int unsigned SeedW  = 32;
  localparam int unsigned ValueW = 64;
  localparam int unsigned ProdW  = 47;
  localparam int unsigned RandW  = 15;
  localparam int unsigned StepW  = 3;

  localparam logic [SeedW-1:0] ZeroSeedRepl = 32'h1234_5987;
  localparam logic [14:0]      LcgMult      = 15'd16807;
  localparam logic [SeedW-1:0] LcgMod       = 32'h7FFF_FFFF;
  localparam logic [5:0]       RandShift    = 6'd15;

  typedef enum logic [2:0] {
    OP_SET_SEED = 3'd0,
    OP_DRAW15   = 3'd1,
    OP_DRAW8    = 3'd2,
    OP_DRAW16   = 3'd3,
    OP_DRAW32   = 3'd4,
    OP_DRAW64   = 3'd5,
    OP_STEP_EXT = 3'd6
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [SeedW-1:0] seed_value;
  } in_item_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [SeedW-1:0]  new_seed;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             start;
    logic             mul;
    logic             fold;
    logic             emit;
    logic [StepW-1:0] step_idx;
    op_e              op;
  } cmd_t;

  // Number of chained generator steps an opcode needs.
  function automatic logic [StepW-1:0] steps_for(op_e op);
    logic [StepW-1:0] n;
    case (op)
      OP_DRAW15, OP_DRAW8, OP_STEP_EXT: n = 3'd1;
      OP_DRAW16:                        n = 3'd2;
      OP_DRAW32:                        n = 3'd3;
      OP_DRAW64:                        n = 3'd5;
      default:                          n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// File: hw/rtl/msp_ctrl.sv
// Controller state machine that sequences the generator steps of one item.
module msp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  msp_pkg::op_e  in_op_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output msp_pkg::cmd_t cmd_o
);
  import msp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_FOLD = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  op_e              op_q, op_d;
  logic [StepW-1:0] steps_q, steps_d;
  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             out_free;
  logic [StepW-1:0] step_inc;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign step_inc = step_q + 3'd1;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    steps_d     = steps_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.op    = op_q;
    cmd_o.step_idx = step_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d      = in_op_i;
          steps_d   = steps_for(in_op_i);
          step_d    = '0;
          cmd_o.start = 1'b1;
          cmd_o.op    = in_op_i;
          state_d   = (steps_for(in_op_i) == '0) ? ST_EMIT : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        step_d     = step_inc;
        state_d    = (step_inc == steps_q) ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_SET_SEED;
      steps_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      steps_q     <= steps_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // A result never overwrites one that is still waiting.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result emitted over a stalled result");

  // An accepted item always keeps the controller busy in the cycle after acceptance.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("controller idle right after accepting an item");

  // The step counter stays within the step count of the current item.
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FOLD) |-> (step_q < steps_q))
    else $error("step counter ran past the step count");
`endif

endmodule

// File: hw/rtl/msp_datapath.sv
// Datapath with the seed registers, the shared multiply-and-fold unit and the output register.
module msp_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  msp_pkg::cmd_t                   cmd_i,
  input  logic [msp_pkg::SeedW-1:0]       ext_seed_i,
  output msp_pkg::out_item_t              out_item_o
);
  import msp_pkg::*;

  logic [SeedW-1:0]  stored_seed_q, stored_seed_d;
  logic [SeedW-1:0]  work_seed_q, work_seed_d;
  logic [ProdW-1:0]  prod_q;
  logic [ValueW-1:0] acc_q, acc_d;
  out_item_t         out_q;
  logic [SeedW-1:0]  mul_src;
  logic [SeedW-1:0]  fold_sum;
  logic [SeedW-1:0]  fold_res;
  logic [5:0]        shamt;
  logic [ValueW-1:0] value_mux;

  // 16807 * seed < 2^47; the modulus is 2^31-1, so the high part folds onto the low part.
  assign mul_src  = (work_seed_q == '0) ? ZeroSeedRepl : work_seed_q;
  assign fold_sum = {16'd0, prod_q[ProdW-1:31]} + {1'b0, prod_q[30:0]};
  assign fold_res = (fold_sum >= LcgMod) ? (fold_sum - LcgMod) : fold_sum;
  assign shamt    = 6'(cmd_i.step_idx) * RandShift;

  always_comb begin
    stored_seed_d = stored_seed_q;
    work_seed_d   = work_seed_q;
    acc_d         = acc_q;
    if (cmd_i.start) begin
      acc_d = '0;
      case (cmd_i.op)
        OP_SET_SEED: stored_seed_d = ext_seed_i;
        OP_STEP_EXT: work_seed_d   = ext_seed_i;
        default:     work_seed_d   = stored_seed_q;
      endcase
    end
    if (cmd_i.fold) begin
      work_seed_d = fold_res;
      acc_d       = acc_q | (ValueW'(fold_res[RandW-1:0]) << shamt);
      if (cmd_i.op != OP_STEP_EXT) begin
        stored_seed_d = fold_res;
      end
    end
  end

  always_comb begin
    case (cmd_i.op)
      OP_DRAW15, OP_DRAW64, OP_STEP_EXT: value_mux = acc_q;
      OP_DRAW8:  value_mux = {56'd0, acc_q[7:0]};
      OP_DRAW16: value_mux = {48'd0, acc_q[15:0]};
      OP_DRAW32: value_mux = {32'd0, acc_q[31:0]};
      default:   value_mux = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_seed_q <= '0;
    end else begin
      stored_seed_q <= stored_seed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_seed_q <= work_seed_d;
    acc_q       <= acc_d;
    if (cmd_i.mul) begin
      prod_q <= ProdW'(mul_src) * ProdW'(LcgMult);
    end
    if (cmd_i.emit) begin
      out_q.value    <= value_mux;
      out_q.new_seed <= (cmd_i.op == OP_STEP_EXT) ? work_seed_q : stored_seed_q;
    end
  end

  assign out_item_o = out_q;

`ifndef NO_ASSERTIONS
  // Every folded seed is fully reduced below the modulus.
  a_fold_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fold |=> (work_seed_q < LcgMod))
    else $error("folded seed not reduced");

  // A step from an external seed leaves the stored seed alone.
  a_ext_keeps_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fold && cmd_i.op == OP_STEP_EXT) |=> $stable(stored_seed_q))
    else $error("external step changed the stored seed");

  // An 8-bit draw leaves only the low byte set.
  a_draw8_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.op == OP_DRAW8) |=> (out_q.value[ValueW-1:8] == '0))
    else $error("8-bit draw has high bits set");
`endif

endmodule

// File: hw/rtl/minimal_standard_prng.sv
// Top level of the minimal standard generator: controller and datapath.
//
// Input channel: in_valid_i / in_stall_o carry one item of opcode and seed value.
// An item is taken when in_valid_i is high and in_stall_o is low. The output
// channel out_valid_o / out_stall_i returns exactly one result item per input
// item: the assembled value and the seed after the item.
// Each generator step runs in turn on the one shared unit: a 32x15
// multiply into a product register, then a fold and conditional subtract that
// reduces modulo 2^31-1. An item needs n steps (0 for set seed and the unused
// opcode, 1 for the 15-bit, 8-bit and external-seed steps, 2, 3 and 5 for the
// 16, 32 and 64-bit draws); after its last step the result is written to the
// output register, and the next item is taken only once the controller is idle
// again, so no new item enters while one is still being worked on.
// The result sits in an output register, so a new item is accepted while a
// stalled result waits; the block holds the next result back until that
// register is free. Reset clears the stored seed to zero and drops any
// pending result.
module minimal_standard_prng (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  msp_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output msp_pkg::out_item_t   out_item_o
);
  import msp_pkg::*;

  cmd_t cmd;

  msp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_item_i.op),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  msp_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .ext_seed_i (in_item_i.seed_value),
    .out_item_o (out_item_o)
  );

endmodule
